// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    // Fixed-point format of the inputs: 1/16 degree and 1/16 percent
    localparam int FRAC_BITS = 4;

    // Register stages from input to output
    localparam int NSTAGE = 7;

    // Internal widths
    localparam int HUE_W   = 13;  // clamped hue, below 5760
    localparam int PCT_W   = 11;  // clamped saturation or value, up to 1600
    localparam int REM_W   = 10;  // position inside a sector, below 960
    localparam int TERM_W  = 21;  // A*B - s*k, up to 1536000
    localparam int PROD_W  = 32;  // v * (A*B - s*k)
    localparam int SUM_W   = 41;  // 510*y + D
    localparam int QUO_W   = 22;  // (510*y + D) >> 19
    localparam int RECIP_W = 23;  // reciprocal of 9375
    localparam int EST_W   = 44;  // quotient estimate product
    localparam int CHAN_W  = 8;

    localparam int SPAN_I = 60 << FRAC_BITS;

    localparam logic [HUE_W-1:0]  HUE_MAX = HUE_W'(360 << FRAC_BITS);
    localparam logic [PCT_W-1:0]  PCT_MAX = PCT_W'(100 << FRAC_BITS);
    localparam logic [REM_W-1:0]  SPAN    = REM_W'(SPAN_I);
    // A*B: the full-scale numerator of one channel term
    localparam logic [TERM_W-1:0] FULL    = TERM_W'((100 * 60) << (2 * FRAC_BITS));

    // Denominator D = A*A*B = 2^18 * 9375; rounding adds D to 2*255*num
    localparam logic [SUM_W-1:0]   ROUND_BIAS  = 41'd2457600000;
    localparam int                 PRE_SHIFT   = 19;
    // ceil(2^36 / 9375), exact for every quotient input below 2^22
    localparam logic [RECIP_W-1:0] RECIP       = 23'd7330078;
    localparam int                 RECIP_SHIFT = 36;

    // Hue sectors of 60 degrees
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic st1;
        logic st2;
    } front_en_t;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
    } lane_en_t;

endpackage

// ===== rtl/hsv2rgb_front.sv =====
module hsv2rgb_front (
    input  logic                              clk,
    input  hsv2rgb_pkg::front_en_t            en,
    input  logic signed [13:0]                hue,
    input  logic signed [11:0]                saturation,
    input  logic signed [11:0]                brightness,
    output hsv2rgb_pkg::sector_t              sector,
    output logic [hsv2rgb_pkg::REM_W-1:0]     rem,
    output logic [hsv2rgb_pkg::PCT_W-1:0]     sat,
    output logic [hsv2rgb_pkg::PCT_W-1:0]     val
);

    logic [hsv2rgb_pkg::HUE_W-1:0] h_next, h_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0] s_next, s_reg, v_next, v_reg;
    hsv2rgb_pkg::sector_t          sector_next, sector_reg;
    logic [hsv2rgb_pkg::HUE_W-1:0] base;
    logic [hsv2rgb_pkg::REM_W-1:0] rem_next, rem_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0] s2_reg, v2_reg;

    // Clamp the inputs; hue of 360 degrees and above wraps to red
    always_comb
    begin
        if (hue[13] || (hue[12:0] >= hsv2rgb_pkg::HUE_MAX))
        begin
            h_next = '0;
        end
        else
        begin
            h_next = hue[12:0];
        end
        if (saturation[11])
        begin
            s_next = '0;
        end
        else if (saturation[10:0] > hsv2rgb_pkg::PCT_MAX)
        begin
            s_next = hsv2rgb_pkg::PCT_MAX;
        end
        else
        begin
            s_next = saturation[10:0];
        end
        if (brightness[11])
        begin
            v_next = '0;
        end
        else if (brightness[10:0] > hsv2rgb_pkg::PCT_MAX)
        begin
            v_next = hsv2rgb_pkg::PCT_MAX;
        end
        else
        begin
            v_next = brightness[10:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            h_reg <= h_next;
            s_reg <= s_next;
            v_reg <= v_next;
        end
    end

    // Split hue into sector and position inside the sector
    always_comb
    begin
        if (h_reg >= hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SPAN_I))
        begin
            sector_next = hsv2rgb_pkg::SEC_MAG_RED;
            base        = hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SPAN_I);
        end
        else if (h_reg >= hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SPAN_I))
        begin
            sector_next = hsv2rgb_pkg::SEC_BLU_MAG;
            base        = hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SPAN_I);
        end
        else if (h_reg >= hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SPAN_I))
        begin
            sector_next = hsv2rgb_pkg::SEC_CYN_BLU;
            base        = hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SPAN_I);
        end
        else if (h_reg >= hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SPAN_I))
        begin
            sector_next = hsv2rgb_pkg::SEC_GRN_CYN;
            base        = hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SPAN_I);
        end
        else if (h_reg >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SPAN_I))
        begin
            sector_next = hsv2rgb_pkg::SEC_YEL_GRN;
            base        = hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SPAN_I);
        end
        else
        begin
            sector_next = hsv2rgb_pkg::SEC_RED_YEL;
            base        = '0;
        end
        rem_next = hsv2rgb_pkg::REM_W'(h_reg - base);
    end

    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            sector_reg <= sector_next;
            rem_reg    <= rem_next;
            s2_reg     <= s_reg;
            v2_reg     <= v_reg;
        end
    end

    assign sector = sector_reg;
    assign rem    = rem_reg;
    assign sat    = s2_reg;
    assign val    = v2_reg;

endmodule

// ===== rtl/hsv2rgb_lane.sv =====
module hsv2rgb_lane (
    input  logic                              clk,
    input  hsv2rgb_pkg::lane_en_t             en,
    input  logic [hsv2rgb_pkg::PCT_W-1:0]     sat,
    input  logic [hsv2rgb_pkg::PCT_W-1:0]     val,
    input  logic [hsv2rgb_pkg::REM_W-1:0]     k,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    chan
);

    logic [hsv2rgb_pkg::TERM_W-1:0] sk_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0]  v1_reg;
    logic [hsv2rgb_pkg::PROD_W-1:0] y_reg;
    logic [hsv2rgb_pkg::SUM_W-1:0]  sum_next;
    logic [hsv2rgb_pkg::QUO_W-1:0]  w_reg;
    logic [hsv2rgb_pkg::EST_W-1:0]  est_reg;

    // Scale the sector offset by saturation
    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            sk_reg <= hsv2rgb_pkg::TERM_W'(sat) * hsv2rgb_pkg::TERM_W'(k);
            v1_reg <= val;
        end
    end

    // Form v * (A*B - s*k)
    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            y_reg <= hsv2rgb_pkg::PROD_W'(v1_reg)
                   * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FULL - sk_reg);
        end
    end

    // 2*255*y + D, then drop the power-of-two part of 2*D
    assign sum_next = (hsv2rgb_pkg::SUM_W'(y_reg) << 9)
                    - (hsv2rgb_pkg::SUM_W'(y_reg) << 1)
                    + hsv2rgb_pkg::ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (en.st3)
        begin
            w_reg <= sum_next[hsv2rgb_pkg::SUM_W-1:hsv2rgb_pkg::PRE_SHIFT];
        end
    end

    // Divide by 9375 through the reciprocal
    always_ff @(posedge clk)
    begin
        if (en.st4)
        begin
            est_reg <= hsv2rgb_pkg::EST_W'(w_reg) * hsv2rgb_pkg::EST_W'(hsv2rgb_pkg::RECIP);
        end
    end

    assign chan = est_reg[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CHAN_W];

endmodule

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
// HSV to RGB converter: takes one colour per request (hue in 1/16 degree,
// saturation and value in 1/16 percent, out-of-range values clamped, hue of
// 360 degrees wrapping to red) and returns 8-bit red, green and blue rounded
// to nearest with ties upward. The datapath is a seven-stage pipeline (clamp,
// sector split, four stages of the per-term multiply and constant divide,
// channel placement), and a new request is accepted every cycle unless
// in_stall is high. Each stage holds only while it is full and the stage
// after it is held, so output stall backs up through the pipeline and
// in_stall rises only when all seven stages are full.
module hsv_to_rgb_converter_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [13:0] hue,
    input  logic signed [11:0] saturation,
    input  logic signed [11:0] brightness,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    logic [hsv2rgb_pkg::NSTAGE-1:0] vld_reg;
    logic [hsv2rgb_pkg::NSTAGE-1:0] en;
    hsv2rgb_pkg::sector_t          sector;
    logic [hsv2rgb_pkg::REM_W-1:0] rem;
    logic [hsv2rgb_pkg::PCT_W-1:0] sat, val;
    logic [hsv2rgb_pkg::REM_W-1:0] k_t;
    hsv2rgb_pkg::sector_t          sect2_reg, sect3_reg, sect4_reg, sect5_reg;
    logic [hsv2rgb_pkg::CHAN_W-1:0] cv, cp, cq, ct;
    logic [hsv2rgb_pkg::CHAN_W-1:0] red_next, green_next, blue_next;
    logic [hsv2rgb_pkg::CHAN_W-1:0] red_reg, green_reg, blue_reg;
    hsv2rgb_pkg::front_en_t        front_en;
    hsv2rgb_pkg::lane_en_t         lane_en;

    // Advance a stage when it is empty or the next stage advances
    always_comb
    begin
        en[hsv2rgb_pkg::NSTAGE-1] = !vld_reg[hsv2rgb_pkg::NSTAGE-1] || !out_stall;
        for (int i = hsv2rgb_pkg::NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_stall = !en[0];

    // Move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < hsv2rgb_pkg::NSTAGE; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign front_en = '{st1: en[0], st2: en[1]};
    assign lane_en  = '{st1: en[2], st2: en[3], st3: en[4], st4: en[5]};

    hsv2rgb_front u_front (
        .clk        (clk),
        .en         (front_en),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .sector     (sector),
        .rem        (rem),
        .sat        (sat),
        .val        (val)
    );

    assign k_t = hsv2rgb_pkg::SPAN - rem;

    // v term: no offset
    hsv2rgb_lane u_lane_v (
        .clk  (clk),
        .en   (lane_en),
        .sat  (sat),
        .val  (val),
        .k    ('0),
        .chan (cv)
    );

    // p term: full sector offset
    hsv2rgb_lane u_lane_p (
        .clk  (clk),
        .en   (lane_en),
        .sat  (sat),
        .val  (val),
        .k    (hsv2rgb_pkg::SPAN),
        .chan (cp)
    );

    // q term: falling ramp
    hsv2rgb_lane u_lane_q (
        .clk  (clk),
        .en   (lane_en),
        .sat  (sat),
        .val  (val),
        .k    (rem),
        .chan (cq)
    );

    // t term: rising ramp
    hsv2rgb_lane u_lane_t (
        .clk  (clk),
        .en   (lane_en),
        .sat  (sat),
        .val  (val),
        .k    (k_t),
        .chan (ct)
    );

    // Carry the sector alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sect2_reg <= sector;
        end
        if (en[3])
        begin
            sect3_reg <= sect2_reg;
        end
        if (en[4])
        begin
            sect4_reg <= sect3_reg;
        end
        if (en[5])
        begin
            sect5_reg <= sect4_reg;
        end
    end

    // Place the terms by sector
    always_comb
    begin
        case (sect5_reg)
            hsv2rgb_pkg::SEC_RED_YEL:
            begin
                red_next = cv; green_next = ct; blue_next = cp;
            end
            hsv2rgb_pkg::SEC_YEL_GRN:
            begin
                red_next = cq; green_next = cv; blue_next = cp;
            end
            hsv2rgb_pkg::SEC_GRN_CYN:
            begin
                red_next = cp; green_next = cv; blue_next = ct;
            end
            hsv2rgb_pkg::SEC_CYN_BLU:
            begin
                red_next = cp; green_next = cq; blue_next = cv;
            end
            hsv2rgb_pkg::SEC_BLU_MAG:
            begin
                red_next = ct; green_next = cp; blue_next = cv;
            end
            default:
            begin
                red_next = cv; green_next = cp; blue_next = cq;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = vld_reg[hsv2rgb_pkg::NSTAGE-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // Input is held back only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("input stalled with a free pipeline stage");

    // A result leaves the output stage only when it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(vld_reg[hsv2rgb_pkg::NSTAGE-1]) |-> $past(!out_stall))
        else $error("result dropped while output stalled");

    // A new result comes only from a full stage before it
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[hsv2rgb_pkg::NSTAGE-1]) |-> $past(vld_reg[hsv2rgb_pkg::NSTAGE-2]))
        else $error("result appeared from an empty stage");

    // The number of requests in flight never grows while input is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_stall) && !$past(!rst_n)
            |-> ($countones(vld_reg) <= $countones($past(vld_reg))))
        else $error("request entered while input stalled");

endmodule

// ===== bench/rgb_result_checker.sv =====
`timescale 1ns / 100ps

module rgb_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [13:0] hue,
    input  logic signed [11:0] saturation,
    input  logic signed [11:0] brightness,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    output int                 fail_count,
    output int                 colors_owed
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam longint SCALE    = longint'(1) << hsv2rgb_pkg::FRAC_BITS;
    localparam longint HUE_TOP  = 360 * SCALE;
    localparam longint PCT_TOP  = 100 * SCALE;
    localparam longint SEC_SPAN = 60 * SCALE;

    rgb_t colors_due[$];

    initial fail_count = 0;
    initial colors_owed = 0;

    // Round num/den to nearest, ties upward
    function automatic longint unsigned round_up_div(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic longint clamp_to(longint x, longint top);
        if (x < 0)
            return 0;
        if (x > top)
            return top;
        return x;
    endfunction

    // Predict the color for one request
    function automatic rgb_t hsv_to_rgb(logic signed [13:0] h_in, logic signed [11:0] s_in,
                                        logic signed [11:0] v_in);
        longint          h, s, v, sec, pos;
        longint unsigned a, b, d, full, tv, tp, tq, tt;
        rgb_t            c;
        h = clamp_to(longint'(h_in), HUE_TOP);
        s = clamp_to(longint'(s_in), PCT_TOP);
        v = clamp_to(longint'(v_in), PCT_TOP);
        // a hue of a full turn wraps back to red
        if (h == HUE_TOP)
            h = 0;
        sec = h / SEC_SPAN;
        pos = h - sec * SEC_SPAN;
        a = PCT_TOP;
        b = SEC_SPAN;
        d = a * a * b;
        full = a * b;
        tv = round_up_div(255 * v * full, d);
        tp = round_up_div(255 * v * (a - s) * b, d);
        tq = round_up_div(255 * v * (full - s * pos), d);
        tt = round_up_div(255 * v * (full - s * (b - pos)), d);
        case (hsv2rgb_pkg::sector_t'(sec[2:0]))
            hsv2rgb_pkg::SEC_RED_YEL: c = '{r: tv[7:0], g: tt[7:0], b: tp[7:0]};
            hsv2rgb_pkg::SEC_YEL_GRN: c = '{r: tq[7:0], g: tv[7:0], b: tp[7:0]};
            hsv2rgb_pkg::SEC_GRN_CYN: c = '{r: tp[7:0], g: tv[7:0], b: tt[7:0]};
            hsv2rgb_pkg::SEC_CYN_BLU: c = '{r: tp[7:0], g: tq[7:0], b: tv[7:0]};
            hsv2rgb_pkg::SEC_BLU_MAG: c = '{r: tt[7:0], g: tp[7:0], b: tv[7:0]};
            default:                  c = '{r: tv[7:0], g: tp[7:0], b: tq[7:0]};
        endcase
        return c;
    endfunction

    // Queue a prediction per accepted request, compare each accepted result
    always @(posedge clk) begin
        rgb_t want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                colors_due.push_back(hsv_to_rgb(hue, saturation, brightness));
                colors_owed = colors_owed + 1;
            end
            if (out_valid && !out_stall) begin
                if (colors_due.size() == 0) begin
                    $error("result %0d/%0d/%0d with no request outstanding", red, green, blue);
                    fail_count = fail_count + 1;
                end else begin
                    want = colors_due.pop_front();
                    colors_owed = colors_owed - 1;
                    if (red !== want.r) begin
                        $error("red: expected %0d, got %0d", want.r, red);
                        fail_count = fail_count + 1;
                    end
                    if (green !== want.g) begin
                        $error("green: expected %0d, got %0d", want.g, green);
                        fail_count = fail_count + 1;
                    end
                    if (blue !== want.b) begin
                        $error("blue: expected %0d, got %0d", want.b, blue);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/hsv_to_rgb_converter_unit_tb.sv =====
`timescale 1ns / 100ps

module hsv_to_rgb_converter_unit_tb;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic signed [13:0] hue        = '0;
    logic signed [11:0] saturation = '0;
    logic signed [11:0] brightness = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;

    int   fail_count;
    int   colors_owed;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;

    hsv_to_rgb_converter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    rgb_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .fail_count  (fail_count),
        .colors_owed (colors_owed)
    );

    always #1 clk = ~clk;

    // Drive output stall: one long hold on request, random stalls otherwise
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            hold_left = 48;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one request, idling first at random; return right after acceptance
    task automatic send_color(logic [13:0] h, logic [11:0] s, logic [11:0] v);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
    endtask

    // Drop valid and hold until every predicted color has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (colors_owed != 0);
        @(posedge clk);
    endtask

    function automatic logic [13:0] rand_hue();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 14'($urandom);
        if (pick < 30)
            return 14'(960 * $urandom_range(6) + $urandom_range(2) - 1);
        return 14'($urandom_range(5760));
    endfunction

    function automatic logic [11:0] rand_pct();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return 12'($urandom);
        if (pick < 27)
            return 12'(0);
        if (pick < 34)
            return 12'(1600);
        return 12'($urandom_range(1600));
    endfunction

    task automatic run_phase(int s_pct, int r_pct, int count);
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        repeat (count)
            send_color(rand_hue(), rand_pct(), rand_pct());
        drain();
    endtask

    // Give up after a generous bound
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // colors in every sector and on the boundaries, most at full saturation
        send_color(14'(0),    12'(1600), 12'(1600));
        send_color(14'(480),  12'(1600), 12'(1600));
        send_color(14'(1440), 12'(1600), 12'(1600));
        send_color(14'(2400), 12'(1600), 12'(1600));
        send_color(14'(3360), 12'(1600), 12'(1600));
        send_color(14'(4320), 12'(1600), 12'(1600));
        send_color(14'(5280), 12'(1600), 12'(1600));
        send_color(14'(960),  12'(1600), 12'(1600));
        send_color(14'(959),  12'(1200), 12'(1400));
        // full turn wraps to red, just below it stays magenta
        send_color(14'(5760), 12'(1600), 12'(1600));
        send_color(14'(5759), 12'(1600), 12'(1600));
        // hue clamps at both ends
        send_color(14'h1fff,  12'(1600), 12'(1600));
        send_color(14'h2000,  12'(1000), 12'(1600));
        send_color(14'h3fff,  12'(800),  12'(900));
        // zero saturation is grey
        send_color(14'(2000), 12'(0),    12'(800));
        send_color(14'(3000), 12'(0),    12'(1600));
        // zero and clamped saturation and value
        send_color(14'(700),  12'(1600), 12'(0));
        send_color(14'(1700), 12'h7ff,   12'(1600));
        send_color(14'(2700), 12'h800,   12'(1600));
        send_color(14'(3700), 12'hfff,   12'h7ff);
        send_color(14'(4700), 12'(900),  12'h800);
        send_color(14'(1000), 12'(800),  12'(1200));
        send_color(14'(4999), 12'(1),    12'(1));
        drain();

        // random colors under changing back-pressure
        run_phase(35, 62, 200);
        run_phase(62, 35, 200);
        hold_req <= 1'b1;
        run_phase(0, 0, 200);

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
